/* rtl/rla_pkg.sv */
package rla_pkg;

    // Store geometry
    localparam int MAX_LINES  = 1024;
    localparam int NUM_CELLS  = 4;
    localparam int BANK_DEPTH = MAX_LINES / NUM_CELLS;
    localparam int LINE_AW    = $clog2(MAX_LINES);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int CELL_W     = $clog2(NUM_CELLS);

    // Field widths
    localparam int POS_W   = 10;
    localparam int OFS_W   = 31;
    localparam int SLOPE_W = 31;
    localparam int TIME_W  = 20;
    localparam int VAL_W   = 52;
    localparam int PROD_W  = SLOPE_W + TIME_W;
    localparam int LINE_W  = OFS_W + SLOPE_W;

    // Input word layout, lowest field first
    localparam int POS_LSB   = 0;
    localparam int OFS_LSB   = POS_LSB + POS_W;
    localparam int SLOPE_LSB = OFS_LSB + OFS_W;
    localparam int LO_LSB    = SLOPE_LSB + SLOPE_W;
    localparam int HI_LSB    = LO_LSB + POS_W;
    localparam int TIME_LSB  = HI_LSB + POS_W;
    localparam int S_DATA_W  = ((TIME_LSB + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;

    // Read, multiply and compare stages, then one hop per cell
    localparam int DRAIN_CYCLES = 3 + NUM_CELLS;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
        logic [OFS_W-1:0]   offset;
        logic [SLOPE_W-1:0] slope;
    } wr_t;

    typedef struct packed {
        logic               clear;
        logic               active;
        logic [BANK_AW-1:0] idx;
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;
        logic [TIME_W-1:0]  qtime;
    } scan_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } cand_t;

endpackage

/* rtl/rla_cell.sv */
module rla_cell
    import rla_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CELL_W-1:0] cell_index,
    input  wr_t               wr,
    input  scan_t             scan,
    input  cand_t             chain_in,
    output cand_t             chain_out
);

    logic [LINE_W-1:0]  mem [BANK_DEPTH];

    logic [LINE_W-1:0]  rd_reg;
    logic               s1_valid_reg;
    logic [POS_W-1:0]   s1_pos_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic [OFS_W-1:0]   ofs2_reg;
    logic               s2_valid_reg;
    logic [POS_W-1:0]   s2_pos_reg;

    logic               best_valid_reg;
    logic [POS_W-1:0]   best_pos_reg;
    logic [VAL_W-1:0]   best_val_reg;

    cand_t              chain_reg;
    cand_t              chain_next;

    logic [POS_W-1:0]   scan_pos;
    logic               in_range;
    logic [VAL_W-1:0]   s2_val;
    logic               take_own;

    assign scan_pos = POS_W'({cell_index, scan.idx});
    assign in_range = (scan_pos >= scan.lo) && (scan_pos <= scan.hi);
    assign s2_val   = VAL_W'(ofs2_reg) + VAL_W'(prod_reg);

    // Bank write: upper position bits select the cell
    always_ff @(posedge aclk) begin
        if (wr.en && (wr.addr[LINE_AW-1:BANK_AW] == cell_index)) begin
            mem[wr.addr[BANK_AW-1:0]] <= {wr.slope, wr.offset};
        end
        rd_reg     <= mem[scan.idx];
        s1_pos_reg <= scan_pos;
        prod_reg   <= PROD_W'(rd_reg[LINE_W-1:OFS_W]) * PROD_W'(scan.qtime);
        ofs2_reg   <= rd_reg[OFS_W-1:0];
        s2_pos_reg <= s1_pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= scan.active && in_range;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Local best over the bank; strictly greater keeps the lowest position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
        end else if (scan.clear) begin
            best_valid_reg <= 1'b0;
        end else if (s2_valid_reg && (!best_valid_reg || (s2_val > best_val_reg))) begin
            best_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!scan.clear && s2_valid_reg && (!best_valid_reg || (s2_val > best_val_reg))) begin
            best_pos_reg <= s2_pos_reg;
            best_val_reg <= s2_val;
        end
    end

    // Merge with the candidate from lower positions; hand result onward
    assign take_own = best_valid_reg && (!chain_in.valid || (best_val_reg > chain_in.val));

    always_comb begin
        if (take_own) begin
            chain_next.valid = 1'b1;
            chain_next.pos   = best_pos_reg;
            chain_next.val   = best_val_reg;
        end else begin
            chain_next = chain_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg.valid <= 1'b0;
        end else begin
            chain_reg.valid <= chain_next.valid;
        end
        chain_reg.pos <= chain_next.pos;
        chain_reg.val <= chain_next.val;
    end

    assign chain_out = chain_reg;

endmodule

/* rtl/rla_ctrl.sv */
module rla_ctrl
    import rla_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output wr_t                 wr,
    output scan_t               scan,
    input  cand_t               result
);

    state_t             state_reg, state_next;
    logic [BANK_AW-1:0] idx_reg, idx_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [VAL_W-1:0]   out_val_reg, out_val_next;

    logic [POS_W-1:0]   in_pos;
    logic [POS_W-1:0]   in_hi;
    logic [POS_W-1:0]   in_hi_sat;
    logic               accept;

    assign in_pos    = s_tdata[POS_LSB +: POS_W];
    assign in_hi     = s_tdata[HI_LSB +: POS_W];
    assign in_hi_sat = (int'(in_hi) > MAX_LINES - 1) ? POS_W'(MAX_LINES - 1) : in_hi;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        drain_next     = drain_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_pos_next   = out_pos_reg;
        out_val_next   = out_val_reg;

        s_tready  = (state_reg == ST_IDLE);

        wr.en     = accept && (s_tuser == OP_LOAD) && (int'(in_pos) < MAX_LINES);
        wr.addr   = in_pos[LINE_AW-1:0];
        wr.offset = s_tdata[OFS_LSB +: OFS_W];
        wr.slope  = s_tdata[SLOPE_LSB +: SLOPE_W];

        scan.clear  = accept && (s_tuser == OP_QUERY);
        scan.active = (state_reg == ST_SCAN);
        scan.idx    = idx_reg;
        scan.lo     = lo_reg;
        scan.hi     = hi_reg;
        scan.qtime  = time_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == OP_QUERY)) begin
                    lo_next    = s_tdata[LO_LSB +: POS_W];
                    hi_next    = in_hi_sat;
                    time_next  = s_tdata[TIME_LSB +: TIME_W];
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == BANK_AW'(BANK_DEPTH - 1)) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = result.valid ? result.pos : '0;
                    out_val_next   = result.valid ? result.val : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            drain_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            drain_reg     <= drain_next;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        time_reg    <= time_next;
        out_pos_reg <= out_pos_next;
        out_val_reg <= out_val_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - POS_W - VAL_W){1'b0}}, out_val_reg, out_pos_reg};

endmodule

/* rtl/range_line_argmax.sv */
// Load word: stored in the accept cycle, one load per cycle while idle.
// Query word: the four cells scan their BANK_DEPTH (256) positions in
//   parallel, then drain through three pipeline stages and one hop per
//   cell, then the result is registered for output; no new word is taken
//   until the result has been handed to the output register.
// Reset (aresetn low, synchronous) clears control and the valid flags only.
module range_line_argmax
    import rla_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata: position[9:0], offset[40:10], slope[71:41],
    //          range_low[81:72], range_high[91:82], query_time[111:92]
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: operation[0] (0 load, 1 query)
    input  logic                s_tuser,
    // m_tdata: best_position[9:0], best_value[61:10], zero pad[63:62]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    wr_t   wr;
    scan_t scan;
    cand_t chain [NUM_CELLS+1];

    // Lowest positions enter the chain first; an empty candidate starts it
    assign chain[0] = '0;

    rla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr       (wr),
        .scan     (scan),
        .result   (chain[NUM_CELLS])
    );

    // Each cell owns a contiguous bank of positions, scans it in step with
    // the others and merges its local best into the running candidate.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rla_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (CELL_W'(k)),
            .wr         (wr),
            .scan       (scan),
            .chain_in   (chain[k]),
            .chain_out  (chain[k+1])
        );
    end

endmodule

/* rtl/rla_checker.sv */
module rla_checker
    import rla_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:POS_W+VAL_W] == '0))
        else $error("result pad bits not zero");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
        else $error("input taken during query scan");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_LOAD) |=> s_tready)
        else $error("load stalled the input");

    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a query in progress");

endmodule

bind range_line_argmax rla_checker u_rla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
